// ===== rtl/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types, constants and the key sequence table of the terminal key
// sequence decoder.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int unsigned RowBytes = 8;

  localparam logic [7:0] EscByte   = 8'h1B;
  localparam logic [7:0] BrackByte = 8'h5B;
  localparam logic [7:0] MByte     = 8'h4D;
  localparam logic [7:0] EscRow    = 8'd68;

  localparam logic [1:0] KindKey      = 2'd0;
  localparam logic [1:0] KindChar     = 2'd1;
  localparam logic [1:0] KindUnhandled = 2'd2;
  localparam logic [1:0] KindOverflow = 2'd3;

  localparam logic [15:0] EscTimeoutReset = 16'd120;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } tkd_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  key_row;
    logic [3:0]  byte_count;
    logic [63:0] seq_bytes;
  } tkd_out_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] bytes;   // byte 0 in bits 7:0
  } tkd_row_t;

  // Raw sequence text, right justified as string literals are.
  function automatic logic [63:0] tkd_row_text(input logic [7:0] idx);
    logic [63:0] s;
    case (idx)
      8'd0:   s = "\033[A";
      8'd1:   s = "\033[B";
      8'd2:   s = "\033[C";
      8'd3:   s = "\033[D";
      8'd4:   s = "\033[1;2A";
      8'd5:   s = "\033[1;2B";
      8'd6:   s = "\033[1;2C";
      8'd7:   s = "\033[1;2D";
      8'd8:   s = "\033[1;3A";
      8'd9:   s = "\033[1;3B";
      8'd10:  s = "\033[1;3C";
      8'd11:  s = "\033[1;3D";
      8'd12:  s = "\033[1;4A";
      8'd13:  s = "\033[1;4B";
      8'd14:  s = "\033[1;4C";
      8'd15:  s = "\033[1;4D";
      8'd16:  s = "\033[1;5A";
      8'd17:  s = "\033[1;5B";
      8'd18:  s = "\033[1;5C";
      8'd19:  s = "\033[1;5D";
      8'd20:  s = "\033OA";
      8'd21:  s = "\033OB";
      8'd22:  s = "\033OC";
      8'd23:  s = "\033OD";
      8'd24:  s = "\033[1;6A";
      8'd25:  s = "\033[1;6B";
      8'd26:  s = "\033[1;6C";
      8'd27:  s = "\033[1;6D";
      8'd28:  s = "\033Oa";
      8'd29:  s = "\033Ob";
      8'd30:  s = "\033Oc";
      8'd31:  s = "\033Od";
      8'd32:  s = "\033[a";
      8'd33:  s = "\033[b";
      8'd34:  s = "\033[c";
      8'd35:  s = "\033[d";
      8'd36:  s = "\033[2~";
      8'd37:  s = "\033[3~";
      8'd38:  s = "\033[5~";
      8'd39:  s = "\033[6~";
      8'd40:  s = "\033OH";
      8'd41:  s = "\033OF";
      8'd42:  s = "\033[H";
      8'd43:  s = "\033[F";
      8'd44:  s = "\033[3;5~";
      8'd45:  s = "\033[3;2~";
      8'd46:  s = "\033[3;6~";
      8'd47:  s = "\033[11~";
      8'd48:  s = "\033[12~";
      8'd49:  s = "\033[13~";
      8'd50:  s = "\033[14~";
      8'd51:  s = "\033OP";
      8'd52:  s = "\033OQ";
      8'd53:  s = "\033OR";
      8'd54:  s = "\033OS";
      8'd55:  s = "\033[15~";
      8'd56:  s = "\033[16~";
      8'd57:  s = "\033[17~";
      8'd58:  s = "\033[18~";
      8'd59:  s = "\033[19~";
      8'd60:  s = "\033[20~";
      8'd61:  s = "\033[21~";
      8'd62:  s = "\033[22~";
      8'd63:  s = "\033[23~";
      8'd64:  s = "\011";
      8'd65:  s = "\033[Z";
      8'd66:  s = "\177";
      8'd67:  s = " ";
      8'd68:  s = "\033";
      8'd69:  s = "\012";
      8'd70:  s = "\015";
      8'd71:  s = "\001";
      8'd72:  s = "\002";
      8'd73:  s = "\003";
      8'd74:  s = "\004";
      8'd75:  s = "\005";
      8'd76:  s = "\006";
      8'd77:  s = "\007";
      8'd78:  s = "\010";
      8'd79:  s = "\011";
      8'd80:  s = "\012";
      8'd81:  s = "\013";
      8'd82:  s = "\014";
      8'd83:  s = "\016";
      8'd84:  s = "\017";
      8'd85:  s = "\020";
      8'd86:  s = "\021";
      8'd87:  s = "\022";
      8'd88:  s = "\023";
      8'd89:  s = "\024";
      8'd90:  s = "\025";
      8'd91:  s = "\026";
      8'd92:  s = "\027";
      8'd93:  s = "\030";
      8'd94:  s = "\031";
      8'd95:  s = "\032";
      8'd96:  s = "\0330";
      8'd97:  s = "\0331";
      8'd98:  s = "\0332";
      8'd99:  s = "\0333";
      8'd100: s = "\0334";
      8'd101: s = "\0335";
      8'd102: s = "\0336";
      8'd103: s = "\0337";
      8'd104: s = "\0338";
      8'd105: s = "\0339";
      8'd106: s = "\033+";
      8'd107: s = "\033-";
      8'd108: s = "\033/";
      8'd109: s = "\033a";
      8'd110: s = "\033b";
      8'd111: s = "\033c";
      8'd112: s = "\033d";
      8'd113: s = "\033e";
      8'd114: s = "\033f";
      8'd115: s = "\033g";
      8'd116: s = "\033h";
      8'd117: s = "\033i";
      8'd118: s = "\033j";
      8'd119: s = "\033k";
      8'd120: s = "\033l";
      8'd121: s = "\033m";
      8'd122: s = "\033n";
      8'd123: s = "\033o";
      8'd124: s = "\033p";
      8'd125: s = "\033q";
      8'd126: s = "\033r";
      8'd127: s = "\033s";
      8'd128: s = "\033t";
      8'd129: s = "\033u";
      8'd130: s = "\033v";
      8'd131: s = "\033w";
      8'd132: s = "\033x";
      8'd133: s = "\033y";
      8'd134: s = "\033z";
      8'd135: s = "\033[1~";
      8'd136: s = "\033[4~";
      8'd137: s = "\033[[A";
      8'd138: s = "\033[[B";
      8'd139: s = "\033[[C";
      8'd140: s = "\033[[D";
      8'd141: s = "\033[[E";
      8'd142: s = "\033[[F";
      8'd143: s = "\033[[G";
      8'd144: s = "\033[[H";
      8'd145: s = "\033[[I";
      8'd146: s = "\033[[J";
      8'd147: s = "\033[[K";
      8'd148: s = "\033[[L";
      default: s = 64'd0;
    endcase
    return s;
  endfunction

  // Table row with its length and bytes in arrival order.
  function automatic tkd_row_t tkd_row(input logic [7:0] idx);
    logic [63:0] s;
    tkd_row_t    r;
    s = tkd_row_text(idx);
    r.len = 4'd0;
    r.bytes = 64'd0;
    for (int i = 0; i < RowBytes; i++) begin
      if (s[8*i +: 8] != 8'd0) begin
        r.len = r.len + 4'd1;
      end
    end
    for (int i = 0; i < RowBytes; i++) begin
      if (4'(i) < r.len) begin
        r.bytes[8*i +: 8] = s[8*(r.len - 4'(i) - 4'd1) +: 8];
      end
    end
    return r;
  endfunction

  // Continuation bytes that follow a UTF-8 lead byte.
  function automatic logic [1:0] tkd_utf8_extra(input logic [7:0] lead);
    logic [1:0] n;
    if ((lead & 8'h80) == 8'h00) begin
      n = 2'd0;
    end else if ((lead & 8'hE0) == 8'hC0) begin
      n = 2'd1;
    end else if ((lead & 8'hF0) == 8'hE0) begin
      n = 2'd2;
    end else if ((lead & 8'hF8) == 8'hF0) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

// ===== rtl/tkd_ram.sv =====
// ----------------------------------------------------------------------------
// tkd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tkd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/terminal_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes terminal input bytes and timer ticks into key events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction
//   per received byte or timer tick. Output channel (out_valid_o/out_ready_i/
//   out_data_o) carries at most one key event per input transaction.
//   cfg_we_i/cfg_data_i write the escape timeout in ticks; write only when
//   the block is idle.
//   The sequence buffer lives in a small RAM. A byte is written, then the
//   first min(fill,8) buffered bytes are read back one per cycle into a
//   compare window, then the key table is scanned one row per cycle.
//   A key match ends the table scan early and a mouse report prefix skips it.
//   The input is taken again once the item is finished; a finished event
//   sits in the output register, so the next item can start while it waits.
//   Only if an event is ready while the previous one is still not taken
//   does the block hold until out_ready_i.
//   Reset empties the buffer and sets the timeout to 120 ticks; buffer RAM
//   contents need no clearing.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder #(
  parameter int unsigned MaxSeqBytes = 10,
  parameter int unsigned TableRows   = 149
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tkd_pkg::tkd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tkd_pkg::tkd_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i
);
  import tkd_pkg::*;

  localparam int unsigned FW = $clog2(MaxSeqBytes + 1);
  localparam int unsigned AW = $clog2(MaxSeqBytes);
  localparam int unsigned RW = $clog2(TableRows + 1);
  localparam int unsigned CW = (FW > 4) ? FW : 4;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLoad   = 3'd1;
  localparam logic [2:0] StMouse  = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;
  localparam logic [2:0] StTick   = 3'd5;
  localparam logic [2:0] StEmit   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [1:0]    utf_q, utf_d;
  logic [15:0]   wait_q, wait_d;
  logic [15:0]   timeout_q;
  logic [7:0]    win_q [RowBytes];
  logic [7:0]    win_d [RowBytes];
  logic [3:0]    cnt_q, cnt_d;
  logic [3:0]    nload_q, nload_d;
  logic          pend_q, pend_d;
  logic [2:0]    pidx_q, pidx_d;
  logic          charmode_q, charmode_d;
  logic [RW-1:0] row_q, row_d;
  logic          prefix_q, prefix_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    erow_q, erow_d;
  logic          ovalid_q, ovalid_d;
  tkd_out_t      odata_q, odata_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  tkd_row_t      row;
  logic          same;
  logic [63:0]   win_flat;
  logic [FW-1:0] f0;
  logic [15:0]   wait_inc;
  logic [1:0]    n3;
  logic          mouse;

  tkd_ram #(.Width(8), .Depth(MaxSeqBytes)) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_data_i.byte_value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < RowBytes; i++) begin
      win_flat[8*i +: 8] = win_q[i];
    end
  end

  always_comb begin
    row  = tkd_row(8'(row_q));
    same = (CW'(fill_q) <= CW'(row.len));
    for (int i = 0; i < RowBytes; i++) begin
      if ((CW'(i) < CW'(fill_q)) && (row.bytes[8*i +: 8] != win_q[i])) begin
        same = 1'b0;
      end
    end
  end

  assign n3    = (CW'(fill_q) < CW'(3)) ? fill_q[1:0] : 2'd3;
  assign mouse = (win_q[0] == EscByte) && ((n3 < 2'd2) || (win_q[1] == BrackByte)) &&
                 ((n3 < 2'd3) || (win_q[2] == MByte));
  assign f0       = (CW'(fill_q) >= CW'(MaxSeqBytes)) ? '0 : fill_q;
  assign wait_inc = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    utf_d      = utf_q;
    wait_d     = wait_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    nload_d    = nload_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    charmode_d = charmode_q;
    row_d      = row_q;
    prefix_d   = prefix_q;
    kind_d     = kind_q;
    erow_d     = erow_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    ram_we     = 1'b0;
    ram_waddr  = f0[AW-1:0];
    ram_raddr  = cnt_q[AW-1:0];

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          for (int i = 0; i < RowBytes; i++) begin
            win_d[i] = 8'd0;
          end
          cnt_d = 4'd0;
          if (in_data_i.req_type) begin
            // Only a lone escape counts ticks.
            if ((fill_q == FW'(1)) && (utf_q == 2'd0)) begin
              ram_raddr = '0;
              state_d   = StTick;
            end
          end else begin
            ram_we = 1'b1;
            fill_d = f0 + FW'(1);
            wait_d = 16'd0;
            nload_d = (CW'(f0) + CW'(1) > CW'(RowBytes)) ? 4'(RowBytes)
                                                         : 4'(f0 + FW'(1));
            if (CW'(fill_q) >= CW'(MaxSeqBytes)) begin
              utf_d = 2'd0;
            end
            charmode_d = 1'b0;
            if ((CW'(fill_q) < CW'(MaxSeqBytes)) && (utf_q != 2'd0)) begin
              utf_d = utf_q - 2'd1;
              if (utf_q == 2'd1) begin
                charmode_d = 1'b1;
                state_d    = StLoad;
              end
            end else begin
              state_d = StLoad;
            end
          end
        end
      end

      StLoad: begin
        if (pend_q) begin
          win_d[pidx_q] = ram_rdata;
        end
        if (cnt_q < nload_q) begin
          ram_raddr = cnt_q[AW-1:0];
          pend_d    = 1'b1;
          pidx_d    = cnt_q[2:0];
          cnt_d     = cnt_q + 4'd1;
        end else if (!pend_q) begin
          if (charmode_q) begin
            kind_d  = KindChar;
            erow_d  = 8'd0;
            state_d = StEmit;
          end else begin
            state_d = StMouse;
          end
        end
      end

      StMouse: begin
        row_d = '0;
        if (mouse) begin
          prefix_d = 1'b1;
          state_d  = StDecide;
        end else begin
          prefix_d = 1'b0;
          state_d  = StScan;
        end
      end

      StScan: begin
        if (same && (CW'(row.len) == CW'(fill_q))) begin
          kind_d  = KindKey;
          erow_d  = 8'(row_q);
          state_d = StEmit;
        end else begin
          prefix_d = prefix_q | same;
          row_d    = row_q + RW'(1);
          if (row_q == RW'(TableRows - 1)) begin
            state_d = StDecide;
          end
        end
      end

      StDecide: begin
        erow_d  = 8'd0;
        state_d = StIdle;
        if (!prefix_q) begin
          if (fill_q == FW'(1)) begin
            if (tkd_utf8_extra(win_q[0]) != 2'd0) begin
              utf_d = tkd_utf8_extra(win_q[0]);
            end else begin
              kind_d  = KindChar;
              state_d = StEmit;
            end
          end else begin
            kind_d  = KindUnhandled;
            state_d = StEmit;
          end
        end else if (CW'(fill_q) >= CW'(MaxSeqBytes)) begin
          kind_d  = KindOverflow;
          state_d = StEmit;
        end
      end

      StTick: begin
        state_d = StIdle;
        if (ram_rdata == EscByte) begin
          wait_d = wait_inc;
          if (wait_inc >= timeout_q) begin
            win_d[0] = EscByte;
            kind_d   = KindKey;
            erow_d   = EscRow;
            state_d  = StEmit;
          end
        end
      end

      StEmit: begin
        // Hold until the output register is free.
        if (!ovalid_q || out_ready_i) begin
          ovalid_d           = 1'b1;
          odata_d.event_kind = kind_q;
          odata_d.key_row    = erow_q;
          odata_d.byte_count = 4'(fill_q);
          odata_d.seq_bytes  = win_flat;
          fill_d             = '0;
          utf_d              = 2'd0;
          wait_d             = 16'd0;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      utf_q     <= 2'd0;
      wait_q    <= 16'd0;
      timeout_q <= EscTimeoutReset;
      ovalid_q  <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      utf_q    <= utf_d;
      wait_q   <= wait_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    cnt_q      <= cnt_d;
    nload_q    <= nload_d;
    pidx_q     <= pidx_d;
    charmode_q <= charmode_d;
    row_q      <= row_d;
    prefix_q   <= prefix_d;
    kind_q     <= kind_d;
    erow_q     <= erow_d;
    odata_q    <= odata_d;
  end

endmodule

// ===== tb/sv/terminal_key_sequence_decoder_test.sv =====
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_test
// Drives terminal bytes and timer ticks into the key sequence decoder and
// compares every key event with a predictor of the decoding rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_test;
  import tkd_pkg::*;

  localparam int unsigned SeqMax    = 10;
  localparam int unsigned KeyRows   = 149;
  localparam int unsigned MouseSkip = 3;
  localparam logic        ReqByte   = 1'b0;
  localparam logic        ReqTick   = 1'b1;
  localparam longint      CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 200;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  tkd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tkd_out_t out_data_o;
  logic     cfg_we_i;
  logic [15:0] cfg_data_i;

  terminal_key_sequence_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Key table copy, built from the raw sequence text.
  logic [7:0]  key_bytes [KeyRows][8];
  logic [3:0]  key_len   [KeyRows];

  // Predictor state.
  logic [7:0]  pend_buf [SeqMax];
  int unsigned pend_fill;
  int unsigned pend_utf8;
  logic [15:0] esc_ticks;
  logic [15:0] esc_limit;

  tkd_out_t    event_queue[$];
  int unsigned mismatches;
  int unsigned events_seen;
  int unsigned items_sent;
  longint      cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic void load_key_table();
    logic [63:0] s;
    int unsigned n;
    for (int r = 0; r < KeyRows; r++) begin
      s = tkd_row_text(8'(r));
      n = 0;
      for (int i = 0; i < 8; i++) begin
        if (s[8*i +: 8] != 8'd0) n++;
      end
      key_len[r] = 4'(n);
      for (int i = 0; i < 8; i++) begin
        key_bytes[r][i] = (i < n) ? s[8*(n - 1 - i) +: 8] : 8'd0;
      end
    end
  endfunction

  function automatic int unsigned utf8_tail(logic [7:0] lead);
    if (lead[7] == 1'b0) return 0;
    if (lead[7:5] == 3'b110) return 1;
    if (lead[7:4] == 4'b1110) return 2;
    if (lead[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  function automatic void push_event(logic [1:0] kind, logic [7:0] row);
    tkd_out_t e;
    e.event_kind = kind;
    e.key_row    = row;
    e.byte_count = 4'(pend_fill);
    e.seq_bytes  = '0;
    for (int i = 0; i < pend_fill && i < 8; i++) e.seq_bytes[8*i +: 8] = pend_buf[i];
    event_queue.push_back(e);
    pend_fill = 0;
    pend_utf8 = 0;
    esc_ticks = '0;
  endfunction

  function automatic void decode_item(tkd_in_t item);
    bit waiting;
    bit same;
    int unsigned n;
    waiting = 1'b0;
    if (item.req_type == ReqTick) begin
      if (pend_fill == 1 && pend_buf[0] == EscByte && pend_utf8 == 0) begin
        if (esc_ticks != 16'hFFFF) esc_ticks++;
        if (esc_ticks >= esc_limit) push_event(KindKey, EscRow);
      end
      return;
    end
    if (pend_fill >= SeqMax) begin
      pend_fill = 0;
      pend_utf8 = 0;
    end
    pend_buf[pend_fill] = item.byte_value;
    pend_fill++;
    esc_ticks = '0;
    if (pend_utf8 != 0) begin
      pend_utf8--;
      if (pend_utf8 == 0) push_event(KindChar, 8'd0);
      return;
    end
    n = (pend_fill < MouseSkip) ? pend_fill : MouseSkip;
    same = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (pend_buf[i] != ((i == 0) ? EscByte : (i == 1) ? BrackByte : MByte)) same = 1'b0;
    end
    if (same) begin
      waiting = 1'b1;
    end else begin
      for (int r = 0; r < KeyRows; r++) begin
        same = (pend_fill <= key_len[r]);
        for (int i = 0; same && i < pend_fill; i++) begin
          if (key_bytes[r][i] != pend_buf[i]) same = 1'b0;
        end
        if (same) begin
          if (key_len[r] == pend_fill) begin
            push_event(KindKey, 8'(r));
            return;
          end
          waiting = 1'b1;
        end
      end
    end
    if (!waiting) begin
      if (pend_fill == 1) begin
        pend_utf8 = utf8_tail(item.byte_value);
        if (pend_utf8 == 0) push_event(KindChar, 8'd0);
        return;
      end
      push_event(KindUnhandled, 8'd0);
      return;
    end
    if (pend_fill >= SeqMax) push_event(KindOverflow, 8'd0);
  endfunction

  // Sender: offers one transaction, predicts its result on acceptance.
  // Inputs are set with blocking writes at the falling edge so that the drop
  // after one transaction and the raise for the next never collide.
  task automatic send_item(logic kind, logic [7:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = '{req_type: kind, byte_value: value};
    do @(posedge clk_i); while (!in_ready_o);
    decode_item('{req_type: kind, byte_value: value});
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_text(logic [7:0] b[$]);
    foreach (b[i]) send_item(ReqByte, b[i]);
  endtask

  // Wait for all expected events plus the slowest item that yields none.
  task automatic settle();
    while (event_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    esc_limit  = value;
  endtask

  // Receiver side.
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    tkd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen++;
      if (event_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event %h", $time, out_data_o);
      end else begin
        want = event_queue.pop_front();
        if (out_data_o.event_kind != want.event_kind)
          $display("%0t: event_kind expected %0d actual %0d", $time, want.event_kind,
                   out_data_o.event_kind);
        if (out_data_o.key_row != want.key_row)
          $display("%0t: key_row expected %0d actual %0d", $time, want.key_row,
                   out_data_o.key_row);
        if (out_data_o.byte_count != want.byte_count)
          $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                   out_data_o.byte_count);
        if (out_data_o.seq_bytes != want.seq_bytes)
          $display("%0t: seq_bytes expected %h actual %h", $time, want.seq_bytes,
                   out_data_o.seq_bytes);
        if (out_data_o != want) mismatches++;
      end
    end
  end

  task automatic test_named_keys();
    send_text('{8'h1B, 8'h5B, 8'h41});
    send_text('{8'h1B, 8'h5B, 8'h31, 8'h3B, 8'h35, 8'h43});
    send_text('{8'h1B, 8'h5B, 8'h5B, 8'h4C});
    send_text('{8'h09});
    send_text('{8'h7F});
    send_text('{8'h1B, 8'h7A});
  endtask

  task automatic test_characters();
    send_text('{8'h00});
    send_text('{8'hFF});
    send_text('{8'h80});
    send_text('{8'hC3, 8'hA9});
    send_text('{8'hE2, 8'h82, 8'hAC});
    send_text('{8'hF0, 8'h9F, 8'h98, 8'h80});
    send_text('{8'h1B, 8'h5B, 8'h00});
  endtask

  task automatic test_mouse_overflow();
    send_text('{8'h1B, 8'h5B, 8'h4D, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26});
    send_text('{8'h1B, 8'h5B, 8'h4D, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h03});
  endtask

  task automatic test_escape_timeout();
    send_item(ReqTick, 8'hFF);
    write_timeout(16'd1);
    send_text('{8'h1B});
    send_item(ReqTick, 8'h00);
    write_timeout(16'd0);
    send_text('{8'h1B});
    send_item(ReqTick, 8'h00);
    write_timeout(16'd3);
    send_text('{8'h1B});
    send_item(ReqTick, 8'h00);
    send_text('{8'h1B});
    repeat (3) send_item(ReqTick, 8'h00);
    write_timeout(16'hFFFF);
    send_text('{8'h1B});
    repeat (4) send_item(ReqTick, 8'h00);
    send_text('{8'h5B, 8'h42});
  endtask

  // Mostly well-formed sequences with random content, some noise.
  task automatic random_item();
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 35) begin
      r = $urandom_range(KeyRows - 1);
      for (int i = 0; i < key_len[r]; i++) send_item(ReqByte, key_bytes[r][i]);
      if (key_len[r] > 2 && $urandom_range(3) == 0) send_item(ReqByte, 8'($urandom));
    end else if (pick < 50) begin
      send_item(ReqByte, 8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 60) begin
      send_item(ReqByte, 8'($urandom_range(8'hC0, 8'hF7)));
      repeat (utf8_tail(pend_buf[0])) send_item(ReqByte, 8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 66) begin
      send_text('{8'h1B, 8'h5B, 8'h4D});
      repeat ($urandom_range(7)) send_item(ReqByte, 8'($urandom));
    end else if (pick < 76) begin
      send_text('{8'h1B});
      repeat ($urandom_range(6)) send_item(ReqTick, 8'($urandom));
    end else if (pick < 84) begin
      send_item(ReqTick, 8'($urandom));
    end else begin
      send_item(ReqByte, 8'($urandom));
    end
  endtask

  task automatic test_random(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_item();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (40) send_item(ReqByte, 8'($urandom_range(8'h20, 8'h7E)));
    join
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    hold_off    = 1'b0;
    mismatches  = 0;
    events_seen = 0;
    items_sent  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pend_fill = 0;
    pend_utf8 = 0;
    esc_ticks = '0;
    esc_limit = EscTimeoutReset;
    load_key_table();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_named_keys();
    test_characters();
    test_mouse_overflow();
    test_escape_timeout();
    write_timeout(16'd2);
    send_idle_pct = 6;
    recv_idle_pct = 84;
    test_random(615);
    test_backpressure();
    write_timeout(16'd1);
    send_idle_pct = 84;
    recv_idle_pct = 6;
    test_random(615);
    write_timeout(16'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(615);
    settle();

    $display("decoded %0d events from %0d byte and tick transactions", events_seen,
             items_sent);
    $display("covered named keys, UTF-8, mouse reports, overflow, escape timeouts");
    if (mismatches == 0 && event_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
